// ----- rtl/core/swsp_pkg.sv -----
package swsp_pkg;

    // Defaults for the top-level parameters
    localparam int ENCODER_COUNTS_DEF = 8192;
    localparam int GEAR_RATIO_DEF     = 72;
    localparam int CORDIC_STAGES_DEF  = 24;

    // Square root steps: two radicand bits per step over a 64 bit radicand
    localparam int SQRT_STEPS = 32;
    localparam int NUM_WHEELS = 4;

    localparam int CMD_W   = 16;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 24;
    localparam int DIST_W  = 10;
    localparam int GAIN_W  = 8;
    localparam int VEC_W   = 29;   // wheel vector component, Q.8
    localparam int SQ_W    = 54;   // sum of squares bound
    localparam int CRD_W   = 50;   // CORDIC datapath, vector scaled by 2^20
    localparam int CRD_SH  = 20;
    localparam int MOD_W   = 33;   // offset position for the modulo sweep
    localparam int REM_W   = 36;

    typedef enum logic [1:0] {
        REG_X_OFS      = 2'd0,
        REG_Y_OFS      = 2'd1,
        REG_SPEED_GAIN = 2'd2
    } t_reg_idx;

    localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic [31:0] PHASE_3QUART  = 32'hC000_0000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1,         32'd0
    };

    typedef struct packed {
        logic [DIST_W-1:0] x_ofs;
        logic [DIST_W-1:0] y_ofs;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // State carried through the shared iteration stages of one lane
    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [31:0]             acc;
        logic                    spec;   // heading settled without CORDIC
        logic [31:0]             sph;
        logic [MOD_W-1:0]        u;
        logic [63:0]             v;
        logic [REM_W-1:0]        rem;
        logic [31:0]             root;
        logic signed [POS_W-1:0] pos;
    } t_iter;

    // Smallest shift that lifts one turn to at least 2^31
    function automatic int mod_shift(input int t);
        int m;
        m = 0;
        for (int k = 0; k < 32; k++) begin
            if ((64'(t) << m) < 64'h8000_0000) begin
                m = m + 1;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/swsp_step.sv -----
module swsp_step
    import swsp_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int MOD_STEPS     = 24,
    parameter int TURN          = ENCODER_COUNTS_DEF * GEAR_RATIO_DEF
) (
    input  t_iter i_cur,
    output t_iter o_nxt
);

    localparam int MSH  = (IDX < MOD_STEPS) ? (MOD_STEPS - 1 - IDX) : 0;
    localparam logic [MOD_W-1:0] MOD_SUB = MOD_W'(TURN) << MSH;
    localparam int PAIR = SQRT_STEPS - 1 - IDX;
    localparam int ATI  = (IDX < 32) ? IDX : 31;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {i_cur.rem[REM_W-3:0], i_cur.v[2*PAIR+1 -: 2]};
    assign trial  = REM_W'({i_cur.root, 2'b01});

    always_comb begin
        o_nxt = i_cur;
        // vectoring step: drive y toward zero
        if (IDX < CORDIC_STAGES) begin
            if (i_cur.y > 0) begin
                o_nxt.x   = i_cur.x + (i_cur.y >>> IDX);
                o_nxt.y   = i_cur.y - (i_cur.x >>> IDX);
                o_nxt.acc = i_cur.acc + ATAN_TAB[ATI];
            end else begin
                o_nxt.x   = i_cur.x - (i_cur.y >>> IDX);
                o_nxt.y   = i_cur.y + (i_cur.x >>> IDX);
                o_nxt.acc = i_cur.acc - ATAN_TAB[ATI];
            end
        end
        // modulo sweep: drop one scaled turn if it fits
        if (IDX < MOD_STEPS) begin
            if (i_cur.u >= MOD_SUB) begin
                o_nxt.u = i_cur.u - MOD_SUB;
            end
        end
        // square root: one result bit per step
        if (rem_sh >= trial) begin
            o_nxt.rem  = rem_sh - trial;
            o_nxt.root = {i_cur.root[30:0], 1'b1};
        end else begin
            o_nxt.rem  = rem_sh;
            o_nxt.root = {i_cur.root[30:0], 1'b0};
        end
    end

endmodule

// ----- rtl/core/swsp_lane.sv -----
module swsp_lane
    import swsp_pkg::*;
#(
    parameter int   ENCODER_COUNTS = ENCODER_COUNTS_DEF,
    parameter int   GEAR_RATIO     = GEAR_RATIO_DEF,
    parameter int   CORDIC_STAGES  = CORDIC_STAGES_DEF,
    parameter logic POS_X          = 1'b1,
    parameter logic POS_Y          = 1'b1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_load,
    input  t_cfg                     i_cfg,
    input  logic signed [CMD_W-1:0]  i_vx,
    input  logic signed [CMD_W-1:0]  i_vy,
    input  logic signed [CMD_W-1:0]  i_turn,
    input  logic signed [POS_W-1:0]  i_pos,
    output logic                     o_vld,
    output logic signed [POS_W-1:0]  o_goal,
    output logic [SPEED_W-1:0]       o_speed
);

    localparam int TURN      = ENCODER_COUNTS * GEAR_RATIO;
    localparam int TW        = $clog2(TURN) + 1;
    localparam int PW        = 32 + TW;
    localparam int MSHIFT    = mod_shift(TURN);
    localparam int MOD_STEPS = MSHIFT + 1;
    localparam logic [MOD_W-1:0] MOD_OFS = MOD_W'(TURN) << MSHIFT;
    localparam logic signed [TW+1:0] T_S    = (TW+2)'(TURN);
    localparam logic signed [TW+1:0] HALF_S = (TW+2)'(TURN / 2);

    // stage A
    logic                    r_va;
    logic signed [27:0]      r_a_mw, r_a_ml;
    logic signed [CMD_W-1:0] r_a_vx, r_a_vy;
    logic signed [POS_W-1:0] r_a_pos;
    logic signed [16:0]      w_rate;
    // stage B
    logic                    r_vb;
    logic signed [VEC_W-1:0] r_b_vx, r_b_vy;
    logic signed [POS_W-1:0] r_b_pos;
    // stage C
    logic                    r_vc;
    logic [SQ_W-1:0]         r_c_sqx, r_c_sqy;
    t_iter                   r_c_it;
    t_iter                   n_c_it;
    logic signed [VEC_W-1:0] xn, yn;
    logic signed [2*VEC_W-1:0] sqx, sqy;
    logic [SQ_W:0]           sq_sum;
    // iterations
    logic                    r_vit [0:SQRT_STEPS];
    t_iter                   r_it  [0:SQRT_STEPS];
    t_iter                   n_it  [0:SQRT_STEPS-1];
    t_iter                   n_it0;
    // post stages
    logic                    r_ve, r_vf, r_vg, r_vh, r_vi;
    logic [PW-1:0]           r_e_prod;
    logic [39:0]             r_e_spd;
    logic [TW-1:0]           r_e_pm, r_f_pm;
    logic [31:0]             ph;
    logic signed [POS_W-1:0] r_e_pos, r_f_pos, r_g_pos, r_h_pos;
    logic [PW:0]             rsum;
    logic [TW:0]             tgt_raw;
    logic [40:0]             ssum;
    logic [TW-1:0]           r_f_tgt;
    logic [SPEED_W-1:0]      r_f_spd, r_g_spd, r_h_spd, r_i_spd;
    logic signed [TW+1:0]    r_g_draw, r_h_d;
    logic signed [POS_W:0]   goal_w;
    logic signed [POS_W-1:0] r_i_goal;

    assign w_rate = 17'sd0 - 17'(i_turn);

    // CORDIC setup, axis shortcuts and modulo offset
    always_comb begin
        xn = (r_b_vx < 0) ? -r_b_vx : r_b_vx;
        yn = (r_b_vx < 0) ? -r_b_vy : r_b_vy;
        n_c_it      = '0;
        n_c_it.x    = CRD_W'(xn) <<< CRD_SH;
        n_c_it.y    = CRD_W'(yn) <<< CRD_SH;
        n_c_it.acc  = (r_b_vx < 0) ? PHASE_HALF : 32'd0;
        n_c_it.u    = MOD_W'(r_b_pos) + MOD_OFS;
        n_c_it.pos  = r_b_pos;
        n_c_it.spec = (r_b_vx == 0) || (r_b_vy == 0);
        if (r_b_vy == 0) begin
            n_c_it.sph = (r_b_vx < 0) ? PHASE_HALF : 32'd0;
        end else begin
            n_c_it.sph = (r_b_vy > 0) ? PHASE_QUARTER : PHASE_3QUART;
        end
    end

    assign sqx    = r_b_vx * r_b_vx;
    assign sqy    = r_b_vy * r_b_vy;
    assign sq_sum = (SQ_W+1)'(r_c_sqx) + (SQ_W+1)'(r_c_sqy);

    // first iteration register takes the radicand
    always_comb begin
        n_it0   = r_c_it;
        n_it0.v = {sq_sum[SQ_W-1:0], 10'd0};
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        swsp_step #(
            .IDX           (g),
            .CORDIC_STAGES (CORDIC_STAGES),
            .MOD_STEPS     (MOD_STEPS),
            .TURN          (TURN)
        ) u_step (
            .i_cur (r_it[g]),
            .o_nxt (n_it[g])
        );
    end

    assign ph      = r_it[SQRT_STEPS].spec ? r_it[SQRT_STEPS].sph : r_it[SQRT_STEPS].acc;
    assign rsum    = {1'b0, r_e_prod} + (PW+1)'(PHASE_HALF);
    assign tgt_raw = rsum[PW:32];
    assign ssum    = {1'b0, r_e_spd} + 41'd4096;
    assign goal_w  = (POS_W+1)'(r_h_pos) + (POS_W+1)'(r_h_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_vit[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_va     <= i_load;
            r_vb     <= r_va;
            r_vc     <= r_vb;
            r_vit[0] <= r_vc;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_vit[k+1] <= r_vit[k];
            end
            r_ve <= r_vit[SQRT_STEPS];
            r_vf <= r_ve;
            r_vg <= r_vf;
            r_vh <= r_vg;
            r_vi <= r_vh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A: rate times wheel offsets
            r_a_mw  <= w_rate * $signed({1'b0, i_cfg.y_ofs});
            r_a_ml  <= w_rate * $signed({1'b0, i_cfg.x_ofs});
            r_a_vx  <= i_vx;
            r_a_vy  <= i_vy;
            r_a_pos <= i_pos;
            // B: wheel vector
            r_b_vx  <= POS_Y ? (VEC_W'($signed({r_a_vx, 8'd0})) - VEC_W'(r_a_mw))
                             : (VEC_W'($signed({r_a_vx, 8'd0})) + VEC_W'(r_a_mw));
            r_b_vy  <= POS_X ? (VEC_W'($signed({r_a_vy, 8'd0})) + VEC_W'(r_a_ml))
                             : (VEC_W'($signed({r_a_vy, 8'd0})) - VEC_W'(r_a_ml));
            r_b_pos <= r_a_pos;
            // C: squares and iteration setup
            r_c_sqx <= sqx[SQ_W-1:0];
            r_c_sqy <= sqy[SQ_W-1:0];
            r_c_it  <= n_c_it;
            r_it[0] <= n_it0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_it[k+1] <= n_it[k];
            end
            // E: phase to counts, magnitude times gain
            r_e_prod <= PW'(ph) * PW'(TURN);
            r_e_spd  <= 40'(r_it[SQRT_STEPS].root) * 40'(i_cfg.gain);
            r_e_pm   <= r_it[SQRT_STEPS].u[TW-1:0];
            r_e_pos  <= r_it[SQRT_STEPS].pos;
            // F: round the target, wrap into one turn, saturate speed
            r_f_tgt <= (tgt_raw >= (TW+1)'(TURN)) ? TW'(tgt_raw - (TW+1)'(TURN))
                                                  : TW'(tgt_raw);
            r_f_spd <= (ssum[40:13] > 28'(24'hFF_FFFF)) ? 24'hFF_FFFF : ssum[36:13];
            r_f_pm  <= r_e_pm;
            r_f_pos <= r_e_pos;
            // G: raw step
            r_g_draw <= $signed({2'b00, r_f_tgt}) - $signed({2'b00, r_f_pm});
            r_g_spd  <= r_f_spd;
            r_g_pos  <= r_f_pos;
            // H: step into the half-open half turn
            if (r_g_draw > HALF_S) begin
                r_h_d <= r_g_draw - T_S;
            end else if (r_g_draw <= -HALF_S) begin
                r_h_d <= r_g_draw + T_S;
            end else begin
                r_h_d <= r_g_draw;
            end
            r_h_spd <= r_g_spd;
            r_h_pos <= r_g_pos;
            // I: goal with saturation
            if (goal_w > (POS_W+1)'(33'sh0_7FFF_FFFF)) begin
                r_i_goal <= 32'sh7FFF_FFFF;
            end else if (goal_w < -(POS_W+1)'(33'sh0_8000_0000)) begin
                r_i_goal <= 32'sh8000_0000;
            end else begin
                r_i_goal <= goal_w[POS_W-1:0];
            end
            r_i_spd <= r_h_spd;
        end
    end

    assign o_vld   = r_vi;
    assign o_goal  = r_i_goal;
    assign o_speed = r_i_spd;

endmodule

// ----- rtl/core/swerve_wheel_setpoints_unit.sv -----
// Channel   | Handshake                       | Payload
// ----------+---------------------------------+-------------------------------------------
// input     | i_in_valid / o_in_ready         | i_cmd_forward, i_cmd_sideways, i_cmd_turn,
//           |                                 | i_steer_pos_0..3
// output    | o_out_valid / i_out_ready       | o_steer_goal_0..3, o_wheel_speed_0..3
// config    | i_cfg_we (no wait)              | i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained unless the output stalls; o_out_valid rises once the
// command has passed the lane pipeline. Its depth is set by the 32 square-root steps, which
// share stages with the CORDIC and the modulo sweep in each of the four wheel lanes.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// A stall on the output freezes the whole pipeline; the output register keeps the
// finished result and the input stays open as long as that register is free or being taken.
module swerve_wheel_setpoints_unit
    import swsp_pkg::*;
#(
    parameter int ENCODER_COUNTS = ENCODER_COUNTS_DEF,
    parameter int GEAR_RATIO     = GEAR_RATIO_DEF,
    parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [CMD_W-1:0] i_cmd_forward,
    input  logic signed [CMD_W-1:0] i_cmd_sideways,
    input  logic signed [CMD_W-1:0] i_cmd_turn,
    input  logic signed [POS_W-1:0] i_steer_pos_0,
    input  logic signed [POS_W-1:0] i_steer_pos_1,
    input  logic signed [POS_W-1:0] i_steer_pos_2,
    input  logic signed [POS_W-1:0] i_steer_pos_3,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [POS_W-1:0] o_steer_goal_0,
    output logic signed [POS_W-1:0] o_steer_goal_1,
    output logic signed [POS_W-1:0] o_steer_goal_2,
    output logic signed [POS_W-1:0] o_steer_goal_3,
    output logic [SPEED_W-1:0]      o_wheel_speed_0,
    output logic [SPEED_W-1:0]      o_wheel_speed_1,
    output logic [SPEED_W-1:0]      o_wheel_speed_2,
    output logic [SPEED_W-1:0]      o_wheel_speed_3,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [DIST_W-1:0]       i_cfg_data
);

    // wheel offset signs: front-right, front-left, rear-left, rear-right
    localparam logic [NUM_WHEELS-1:0] POS_X = 4'b1001;
    localparam logic [NUM_WHEELS-1:0] POS_Y = 4'b0011;

    t_cfg                    r_cfg;
    logic                    en;
    logic                    load;
    logic signed [POS_W-1:0] pos   [NUM_WHEELS];
    logic                    lvld  [NUM_WHEELS];
    logic signed [POS_W-1:0] lgoal [NUM_WHEELS];
    logic [SPEED_W-1:0]      lspd  [NUM_WHEELS];
    logic                    r_out_vld;
    logic signed [POS_W-1:0] r_goal [NUM_WHEELS];
    logic [SPEED_W-1:0]      r_spd  [NUM_WHEELS];

    // advance the whole pipeline whenever the output register can take a result
    assign en         = !r_out_vld || i_out_ready;
    assign load       = i_in_valid && en;
    assign o_in_ready = en;

    assign pos[0] = i_steer_pos_0;
    assign pos[1] = i_steer_pos_1;
    assign pos[2] = i_steer_pos_2;
    assign pos[3] = i_steer_pos_3;

    // configuration registers; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_ofs <= DIST_W'(64);
            r_cfg.y_ofs <= DIST_W'(64);
            r_cfg.gain  <= GAIN_W'(70);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_X_OFS:      r_cfg.x_ofs <= i_cfg_data;
                REG_Y_OFS:      r_cfg.y_ofs <= i_cfg_data;
                REG_SPEED_GAIN: r_cfg.gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // one lane per wheel
    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        swsp_lane #(
            .ENCODER_COUNTS (ENCODER_COUNTS),
            .GEAR_RATIO     (GEAR_RATIO),
            .CORDIC_STAGES  (CORDIC_STAGES),
            .POS_X          (POS_X[g]),
            .POS_Y          (POS_Y[g])
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_load  (load),
            .i_cfg   (r_cfg),
            .i_vx    (i_cmd_forward),
            .i_vy    (i_cmd_sideways),
            .i_turn  (i_cmd_turn),
            .i_pos   (pos[g]),
            .o_vld   (lvld[g]),
            .o_goal  (lgoal[g]),
            .o_speed (lspd[g])
        );
    end

    // merge the four lanes into one output transaction; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= lvld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_goal[k] <= lgoal[k];
                r_spd[k]  <= lspd[k];
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_steer_goal_0  = r_goal[0];
    assign o_steer_goal_1  = r_goal[1];
    assign o_steer_goal_2  = r_goal[2];
    assign o_steer_goal_3  = r_goal[3];
    assign o_wheel_speed_0 = r_spd[0];
    assign o_wheel_speed_1 = r_spd[1];
    assign o_wheel_speed_2 = r_spd[2];
    assign o_wheel_speed_3 = r_spd[3];

    // lanes run in lockstep
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lvld[0] == lvld[1]) && (lvld[0] == lvld[2]) && (lvld[0] == lvld[3]))
        else $error("wheel lanes out of step");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

// ----- tb/tb_swerve_wheel_setpoints_unit.sv -----
module tb_swerve_wheel_setpoints_unit;
    import swsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Steering shaft counts per full turn of the wheel
    localparam longint TURN_COUNTS = longint'(ENCODER_COUNTS_DEF) * longint'(GEAR_RATIO_DEF);
    localparam int     HALF_TURN   = int'(TURN_COUNTS / 2);
    // Index past the last register; the block must drop writes to it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // Cycles to let the pipeline drain, with margin over its depth
    localparam int     DRAIN_CYCLES = 60;
    localparam int     RANDOM_ITEMS = 1400;

    typedef struct {
        logic signed [CMD_W-1:0] fwd;
        logic signed [CMD_W-1:0] side;
        logic signed [CMD_W-1:0] turn;
        logic signed [POS_W-1:0] pos [NUM_WHEELS];
    } t_drive_cmd;

    typedef struct {
        logic signed [POS_W-1:0] goal  [NUM_WHEELS];
        logic [SPEED_W-1:0]      speed [NUM_WHEELS];
    } t_setpoints;

    typedef struct {
        t_drive_cmd cmd;
        bit         typed;       // expectation written out in the row
        t_setpoints sp;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [CMD_W-1:0] i_cmd_forward;
    logic signed [CMD_W-1:0] i_cmd_sideways;
    logic signed [CMD_W-1:0] i_cmd_turn;
    logic signed [POS_W-1:0] i_steer_pos_0;
    logic signed [POS_W-1:0] i_steer_pos_1;
    logic signed [POS_W-1:0] i_steer_pos_2;
    logic signed [POS_W-1:0] i_steer_pos_3;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [POS_W-1:0] o_steer_goal_0;
    logic signed [POS_W-1:0] o_steer_goal_1;
    logic signed [POS_W-1:0] o_steer_goal_2;
    logic signed [POS_W-1:0] o_steer_goal_3;
    logic [SPEED_W-1:0]      o_wheel_speed_0;
    logic [SPEED_W-1:0]      o_wheel_speed_1;
    logic [SPEED_W-1:0]      o_wheel_speed_2;
    logic [SPEED_W-1:0]      o_wheel_speed_3;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [DIST_W-1:0]       i_cfg_data;

    // Shadow copy of the geometry and gain registers
    logic [DIST_W-1:0] half_len_reg;
    logic [DIST_W-1:0] half_wid_reg;
    logic [GAIN_W-1:0] gain_reg;

    t_setpoints pending_setpoints [$];
    t_stim_row  directed_rows [$];
    int         mismatch_cnt;
    int         checked_cnt;
    int         sent_cnt;
    int         idle_mode;       // 0: sender light/receiver heavy, 1: swapped, 2: no idling

    swerve_wheel_setpoints_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd_forward  (i_cmd_forward),
        .i_cmd_sideways (i_cmd_sideways),
        .i_cmd_turn     (i_cmd_turn),
        .i_steer_pos_0  (i_steer_pos_0),
        .i_steer_pos_1  (i_steer_pos_1),
        .i_steer_pos_2  (i_steer_pos_2),
        .i_steer_pos_3  (i_steer_pos_3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_steer_goal_0 (o_steer_goal_0),
        .o_steer_goal_1 (o_steer_goal_1),
        .o_steer_goal_2 (o_steer_goal_2),
        .o_steer_goal_3 (o_steer_goal_3),
        .o_wheel_speed_0(o_wheel_speed_0),
        .o_wheel_speed_1(o_wheel_speed_1),
        .o_wheel_speed_2(o_wheel_speed_2),
        .o_wheel_speed_3(o_wheel_speed_3),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Hard stop in case the pipeline hangs
    initial begin
        #2_000_000;
        $display("FAIL swerve_wheel_setpoints_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Wheel heading as a 32-bit phase, 2^32 per turn
    function automatic logic [31:0] wheel_phase(input longint vec_x, input longint vec_y);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        x   = vec_x;
        y   = vec_y;
        acc = '0;
        // Settle the zero and axis cases exactly, without rotating
        if (x == 0 && y == 0) return '0;
        if (y == 0) return (x < 0) ? PHASE_HALF : '0;
        if (x == 0) return (y > 0) ? PHASE_QUARTER : PHASE_3QUART;
        // Fold the left half-plane onto the right one
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = PHASE_HALF;
        end
        x = x * (longint'(1) << CRD_SH);
        y = y * (longint'(1) << CRD_SH);
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + ATAN_TAB[i];
            end else begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned radicand);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = radicand;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_setpoints predict_setpoints(input t_drive_cmd c);
        t_setpoints      sp;
        longint          vx;
        longint          vy;
        longint          rate;
        longint          off_x;
        longint          off_y;
        longint          wx;
        longint          wy;
        longint          pos;
        longint          tgt;
        longint          pm;
        longint          step;
        longint          goal;
        longint unsigned sumsq;
        longint unsigned root;
        longint unsigned spd;
        logic [31:0]     ph;
        vx   = longint'(c.fwd);
        vy   = longint'(c.side);
        rate = -longint'(c.turn);
        for (int k = 0; k < NUM_WHEELS; k++) begin
            // Front-right and rear-right sit at +x; both front wheels at +y
            off_x = (k == 0 || k == 3) ? longint'(half_len_reg) : -longint'(half_len_reg);
            off_y = (k < 2) ? longint'(half_wid_reg) : -longint'(half_wid_reg);
            wx    = vx * 256 - rate * off_y;
            wy    = vy * 256 + rate * off_x;
            ph    = wheel_phase(wx, wy);
            tgt   = longint'((64'(ph) * 64'(TURN_COUNTS) + 64'h8000_0000) >> 32);
            if (tgt >= TURN_COUNTS) tgt = tgt - TURN_COUNTS;
            // Move to the nearest shaft position with that heading
            pos  = longint'(c.pos[k]);
            pm   = pos % TURN_COUNTS;
            if (pm < 0) pm = pm + TURN_COUNTS;
            step = (tgt - pm) % TURN_COUNTS;
            if (step < 0) step = step + TURN_COUNTS;
            if (step > TURN_COUNTS / 2) step = step - TURN_COUNTS;
            goal = pos + step;
            if (goal > 64'sd2147483647) goal = 64'sd2147483647;
            if (goal < -64'sd2147483648) goal = -64'sd2147483648;
            sp.goal[k] = goal[31:0];

            sumsq = longint'(wx * wx) + longint'(wy * wy);
            root  = int_sqrt(sumsq << 10);
            spd   = (root * longint'(gain_reg) + 4096) >> 13;
            if (spd > 64'hFF_FFFF) spd = 64'hFF_FFFF;
            sp.speed[k] = spd[SPEED_W-1:0];
        end
        return sp;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (idle_mode == 0) begin
            i_out_ready <= ($urandom_range(99) >= 53);
        end else if (idle_mode == 1) begin
            i_out_ready <= ($urandom_range(99) >= 27);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_setpoints exp_sp;
        t_setpoints got_sp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_sp.goal  = '{o_steer_goal_0, o_steer_goal_1, o_steer_goal_2, o_steer_goal_3};
            got_sp.speed = '{o_wheel_speed_0, o_wheel_speed_1, o_wheel_speed_2,
                             o_wheel_speed_3};
            if (pending_setpoints.size() == 0) begin
                $error("result transaction with no command outstanding");
                mismatch_cnt++;
            end else begin
                exp_sp = pending_setpoints.pop_front();
                checked_cnt++;
                for (int k = 0; k < NUM_WHEELS; k++) begin
                    if (got_sp.goal[k] !== exp_sp.goal[k]) begin
                        $error("steer_goal_%0d: expected %0d, got %0d", k,
                               exp_sp.goal[k], got_sp.goal[k]);
                        mismatch_cnt++;
                    end
                    if (got_sp.speed[k] !== exp_sp.speed[k]) begin
                        $error("wheel_speed_%0d: expected %0d, got %0d", k,
                               exp_sp.speed[k], got_sp.speed[k]);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drive one command and hold it until the block takes it
    task automatic send_drive_cmd(input t_drive_cmd c, input bit typed, input t_setpoints sp);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 27 : (idle_mode == 1) ? 53 : 0;
        // Drop valid for a random number of cycles
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_cmd_forward  <= c.fwd;
        i_cmd_sideways <= c.side;
        i_cmd_turn     <= c.turn;
        i_steer_pos_0  <= c.pos[0];
        i_steer_pos_1  <= c.pos[1];
        i_steer_pos_2  <= c.pos[2];
        i_steer_pos_3  <= c.pos[3];
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        // Transaction accepted at this edge
        pending_setpoints.push_back(typed ? sp : predict_setpoints(c));
        sent_cnt++;
    endtask

    // Hold off until the pipeline is empty so a register write cannot hit a live command
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIST_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_X_OFS:      half_len_reg = data;
            REG_Y_OFS:      half_wid_reg = data;
            REG_SPEED_GAIN: gain_reg     = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_geometry(input int len, input int wid, input int gain);
        wait_drained();
        write_reg(REG_X_OFS, DIST_W'(len));
        write_reg(REG_Y_OFS, DIST_W'(wid));
        write_reg(REG_SPEED_GAIN, DIST_W'(gain));
    endtask

    function automatic logic signed [CMD_W-1:0] rand_stick();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return CMD_W'($urandom_range(8)) - 16'sd4;
            default: return CMD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_shaft_pos();
        longint turns;
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF - POS_W'($urandom_range(TURN_COUNTS));
            1: return 32'sh8000_0000 + POS_W'($urandom_range(TURN_COUNTS));
            2: begin
                // Exactly half a turn off a whole turn
                turns = longint'($urandom_range(200)) - 100;
                return POS_W'(turns * TURN_COUNTS + HALF_TURN);
            end
            3: return POS_W'($urandom_range(2 * TURN_COUNTS)) - POS_W'(TURN_COUNTS);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic t_drive_cmd rand_drive_cmd();
        t_drive_cmd c;
        c.fwd  = rand_stick();
        c.side = rand_stick();
        c.turn = rand_stick();
        // Often zero a single axis or the whole command
        case ($urandom_range(9))
            0: begin
                c.fwd  = '0;
                c.side = '0;
                c.turn = '0;
            end
            1: c.side = '0;
            2: c.fwd  = '0;
            3: c.turn = '0;
            default: ;
        endcase
        for (int k = 0; k < NUM_WHEELS; k++) c.pos[k] = rand_shaft_pos();
        return c;
    endfunction

    // Directed row; typed rows give the same goal and speed for every wheel
    task automatic add_row(input int f, input int s, input int t, input int p,
                           input bit typed, input int goal, input int spd);
        t_stim_row r;
        r.cmd.fwd  = CMD_W'(f);
        r.cmd.side = CMD_W'(s);
        r.cmd.turn = CMD_W'(t);
        r.typed    = typed;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            r.cmd.pos[k]  = POS_W'(p);
            r.sp.goal[k]  = POS_W'(goal);
            r.sp.speed[k] = SPEED_W'(spd);
        end
        directed_rows.push_back(r);
    endtask

    initial begin
        t_setpoints no_sp;
        int         geo [7][3];
        int         per_phase;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        i_cmd_forward  = '0;
        i_cmd_sideways = '0;
        i_cmd_turn     = '0;
        i_steer_pos_0  = '0;
        i_steer_pos_1  = '0;
        i_steer_pos_2  = '0;
        i_steer_pos_3  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_X_OFS;
        i_cfg_data     = '0;
        half_len_reg   = DIST_W'(64);
        half_wid_reg   = DIST_W'(64);
        gain_reg       = GAIN_W'(70);
        mismatch_cnt   = 0;
        checked_cnt    = 0;
        sent_cnt       = 0;
        idle_mode      = 0;
        no_sp          = predict_setpoints('{default: '0, pos: '{default: '0}});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero command at rest: heading zero, speed zero
        add_row(0, 0, 0, 0, 1'b1, 0, 0);
        // Exactly opposite heading: step forward by half a turn
        add_row(0, 0, 0, HALF_TURN, 1'b1, int'(TURN_COUNTS), 0);
        add_row(0, 0, 0, -HALF_TURN, 1'b1, 0, 0);
        // Goal past either end of the position range saturates
        add_row(0, 0, 0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 0);
        add_row(0, 0, 0, 32'h8000_0000, 1'b1, 32'h8000_0000, 0);
        // Axis vectors and stick extremes, checked by the predictor
        add_row(1000, 0, 0, 12345, 1'b0, 0, 0);
        add_row(-1000, 0, 0, -777, 1'b0, 0, 0);
        add_row(0, 1000, 0, 5, 1'b0, 0, 0);
        add_row(0, -1000, 0, 300000, 1'b0, 0, 0);
        add_row(32767, 0, 0, 0, 1'b0, 0, 0);
        add_row(-32768, 0, 0, 0, 1'b0, 0, 0);
        add_row(0, 32767, 0, 0, 1'b0, 0, 0);
        add_row(0, -32768, 0, 0, 1'b0, 0, 0);
        add_row(0, 0, 32767, 1, 1'b0, 0, 0);
        add_row(0, 0, -32768, -1, 1'b0, 0, 0);
        add_row(32767, 32767, 32767, 32'h7FFF_FFFF, 1'b0, 0, 0);
        add_row(-32768, -32768, -32768, 32'h8000_0000, 1'b0, 0, 0);
        add_row(-32768, 32767, -32768, 2 * HALF_TURN - 1, 1'b0, 0, 0);
        add_row(1, -1, 1, HALF_TURN + 1, 1'b0, 0, 0);

        foreach (directed_rows[i]) begin
            send_drive_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                           directed_rows[i].typed ? directed_rows[i].sp : no_sp);
        end

        // Register settings for the random part: extremes, odd mixes, the defaults
        geo = '{'{1023, 1023, 255}, '{0, 0, 0}, '{1, 1023, 1},
                '{1023, 0, 128}, '{64, 64, 70}, '{300, 700, 200}, '{512, 256, 255}};
        per_phase = RANDOM_ITEMS / 7;
        for (int ph = 0; ph < 7; ph++) begin
            load_geometry(geo[ph][0], geo[ph][1], geo[ph][2]);
            // Write the unused index with all ones; the registers must hold
            if (ph == 1) write_reg(REG_UNUSED, DIST_W'(1023));
            for (int n = 0; n < per_phase; n++) begin
                idle_mode = ((ph * per_phase + n) * 3) / RANDOM_ITEMS;
                send_drive_cmd(rand_drive_cmd(), 1'b0, no_sp);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d drive commands over 8 geometry and gain settings, checked %0d results.",
                 sent_cnt, checked_cnt);
        $display("Covered saturation of goals and speeds, half-turn steps and axis headings.");
        if (mismatch_cnt == 0) begin
            $display("PASS swerve_wheel_setpoints_unit");
        end else begin
            $display("FAIL swerve_wheel_setpoints_unit");
        end
        $finish;
    end

endmodule
